// ===== sv/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared widths, latencies, status codes and transfer types for the
// triangle circumcircle pipeline.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int COORD_W   = 32;
	localparam int NUM_W     = 102;
	localparam int DEN_W     = 69;
	localparam int QB        = 36;
	localparam int CMP_W     = DEN_W + 1 + QB;
	localparam int QW        = QB + 2;
	localparam int DIV_LAT   = QB + 5;
	localparam int R2_W      = 63;
	localparam int RAD_W     = 32;
	localparam int SQ_LAT    = RAD_W;
	localparam int RSQ_SHIFT = 20;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_COLLINEAR = 2'd1,
		ST_SAT       = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} vertices_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic [R2_W-1:0]           radius_sq;
		logic [RAD_W-1:0]          radius;
		status_t                   status;
	} result_t;

endpackage

// ===== sv/tcc_rdiv.sv =====
// ----------------------------------------------------------------------------
// tcc_rdiv
// Pipelined signed divider, floor((2n+d)/(2d)), one quotient bit per stage,
// with a flag for quotients at or beyond 2^QB.
// ----------------------------------------------------------------------------
module tcc_rdiv (
	input  logic                              clk,
	input  logic signed [tcc_pkg::NUM_W-1:0] num,
	input  logic signed [tcc_pkg::DEN_W-1:0] den,
	output logic signed [tcc_pkg::QW-1:0]    quo,
	output logic                              big,
	output logic                              neg
);

	localparam int NW = tcc_pkg::NUM_W + 1;
	localparam int DW = tcc_pkg::DEN_W + 1;
	localparam int CW = tcc_pkg::CMP_W;
	localparam int QB = tcc_pkg::QB;
	localparam int QW = tcc_pkg::QW;

	logic signed [NW-1:0] n_s1;
	logic signed [DW-1:0] d_s1;
	logic signed [CW-1:0] m_s2;
	logic [DW-1:0]        td_s2;
	logic [CW-1:0]        mag_s3;
	logic [DW-1:0]        td_s3;
	logic                 neg_s3;
	logic [CW-1:0]        rem_s4;
	logic [DW-1:0]        td_s4;
	logic                 neg_s4;
	logic                 big_s4;

	logic [CW-1:0] rem_s [QB];
	logic [QB-1:0] q_s   [QB];
	logic [DW-1:0] td_s  [QB];
	logic          neg_s [QB];
	logic          big_s [QB];

	// sign normalization
	always_ff @(posedge clk) begin
		if (den < 0) begin
			n_s1 <= -NW'(num);
			d_s1 <= -DW'(den);
		end else begin
			n_s1 <= NW'(num);
			d_s1 <= DW'(den);
		end
	end

	// round-half-up numerator
	always_ff @(posedge clk) begin
		m_s2  <= (CW'(n_s1) <<< 1) + CW'(d_s1);
		td_s2 <= {d_s1[DW-2:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		neg_s3 <= m_s2[CW-1];
		mag_s3 <= m_s2[CW-1] ? CW'(-m_s2) : CW'(m_s2);
		td_s3  <= td_s2;
	end

	always_ff @(posedge clk) begin
		big_s4 <= mag_s3 >= {td_s3, QB'(0)};
		rem_s4 <= mag_s3;
		td_s4  <= td_s3;
		neg_s4 <= neg_s3;
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [CW-1:0] rem_in;
		logic [QB-1:0] q_in;
		logic [DW-1:0] td_in;
		logic          neg_in;
		logic          big_in;
		logic [CW-1:0] shd;

		if (k == 0) begin : g_first
			assign rem_in = rem_s4;
			assign q_in   = '0;
			assign td_in  = td_s4;
			assign neg_in = neg_s4;
			assign big_in = big_s4;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign q_in   = q_s[k-1];
			assign td_in  = td_s[k-1];
			assign neg_in = neg_s[k-1];
			assign big_in = big_s[k-1];
		end

		assign shd = CW'(td_in) << (QB - 1 - k);

		always_ff @(posedge clk) begin
			if (rem_in >= shd) begin
				rem_s[k] <= rem_in - shd;
				q_s[k]   <= q_in | (QB'(1) << (QB - 1 - k));
			end else begin
				rem_s[k] <= rem_in;
				q_s[k]   <= q_in;
			end
			td_s[k]  <= td_in;
			neg_s[k] <= neg_in;
			big_s[k] <= big_in;
		end
	end

	// floor for negative quotients
	always_ff @(posedge clk) begin
		if (neg_s[QB-1]) begin
			quo <= -($signed(QW'(q_s[QB-1])) + $signed(QW'(rem_s[QB-1] != '0)));
		end else begin
			quo <= $signed(QW'(q_s[QB-1]));
		end
		big <= big_s[QB-1];
		neg <= neg_s[QB-1];
	end

endmodule

// ===== sv/tcc_isqrt.sv =====
// ----------------------------------------------------------------------------
// tcc_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module tcc_isqrt (
	input  logic                        clk,
	input  logic [tcc_pkg::R2_W-1:0]    value,
	output logic [tcc_pkg::RAD_W-1:0]   root
);

	localparam int W = tcc_pkg::R2_W + 1;
	localparam int N = tcc_pkg::SQ_LAT;

	logic [W-1:0] v_s   [N];
	logic [W-1:0] res_s [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [W-1:0] v_in;
		logic [W-1:0] r_in;
		logic [W-1:0] trial;

		if (k == 0) begin : g_first
			assign v_in = W'(value);
			assign r_in = '0;
		end else begin : g_next
			assign v_in = v_s[k-1];
			assign r_in = res_s[k-1];
		end

		assign trial = r_in + (W'(1) << (W - 2 - 2 * k));

		always_ff @(posedge clk) begin
			if (v_in >= trial) begin
				v_s[k]   <= v_in - trial;
				res_s[k] <= (r_in >> 1) + (W'(1) << (W - 2 - 2 * k));
			end else begin
				v_s[k]   <= v_in;
				res_s[k] <= r_in >> 1;
			end
		end
	end

	assign root = res_s[N-1][tcc_pkg::RAD_W-1:0];

endmodule

// ===== sv/triangle_circumcircle.sv =====
// ----------------------------------------------------------------------------
// triangle_circumcircle
// Circumcentre, squared radius and radius of one triangle per clock.
// ----------------------------------------------------------------------------
// The block takes a new triangle in every cycle and never raises busy. Each
// result appears on result with done high for exactly one cycle; the receiver
// must take it then. The latency is set by the two bit-serial quotient
// pipelines (41 stages) and the square-root pipeline (32 stages) plus the
// product stages.
// ----------------------------------------------------------------------------
module triangle_circumcircle (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tcc_pkg::vertices_t  item,
	output logic                done,
	output tcc_pkg::result_t    result
);

	localparam int NW  = tcc_pkg::NUM_W;
	localparam int DNW = tcc_pkg::DEN_W;
	localparam int QW  = tcc_pkg::QW;
	localparam int DL  = tcc_pkg::DIV_LAT;
	localparam int SL  = tcc_pkg::SQ_LAT;
	localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] CMIN = -32'sh7FFF_FFFF - 32'sd1;

	typedef struct packed {
		logic signed [31:0] x0;
		logic signed [31:0] y0;
		logic               gen;
		logic               coll;
	} dsb_t;

	typedef struct packed {
		logic signed [31:0] ccx;
		logic signed [31:0] ccy;
		logic               sat;
		logic               coll;
		logic               ovf;
		logic [63:0]        r2s;
	} ssb_t;

	function automatic logic [32:0] clamp_coord(
		logic signed [QW-1:0] q,
		logic                 qbig,
		logic                 qneg,
		logic signed [31:0]   off
	);
		logic signed [QW:0] s;
		logic [32:0]        r;
		s = (QW+1)'(q) + (QW+1)'(off);
		if (qbig) begin
			r = qneg ? {1'b1, CMIN} : {1'b1, CMAX};
		end else if (s > (QW+1)'(CMAX)) begin
			r = {1'b1, CMAX};
		end else if (s < (QW+1)'(CMIN)) begin
			r = {1'b1, CMIN};
		end else begin
			r = {1'b0, s[31:0]};
		end
		return r;
	endfunction

	// stage 1: differences
	logic               vld_s1;
	logic signed [32:0] dbx_s1, dby_s1, dqx_s1, dqy_s1, de1_s1, de2_s1;
	logic signed [32:0] sum01_s1, sum12_s1;
	logic signed [31:0] x0_s1, y0_s1, y1_s1, y2_s1, lo_s1, hi_s1;
	logic               lvl01_s1, lvl12_s1;
	logic signed [31:0] lo_c, hi_c;

	assign busy = 1'b0;

	always_comb begin
		lo_c = item.ax;
		hi_c = item.bx;
		if ($signed(item.bx) > $signed(item.ax)) begin
			if ($signed(item.cx) > $signed(item.bx)) hi_c = item.cx;
		end else begin
			if ($signed(item.cx) < $signed(item.ax)) lo_c = item.cx;
		end
	end

	always_ff @(posedge clk) begin
		dbx_s1   <= 33'($signed(item.bx)) - 33'($signed(item.ax));
		dby_s1   <= 33'($signed(item.by)) - 33'($signed(item.ay));
		dqx_s1   <= 33'($signed(item.cx)) - 33'($signed(item.ax));
		dqy_s1   <= 33'($signed(item.cy)) - 33'($signed(item.ay));
		de1_s1   <= 33'($signed(item.cx)) - 33'($signed(item.bx));
		de2_s1   <= 33'($signed(item.ax)) - 33'($signed(item.cx));
		sum01_s1 <= 33'($signed(item.ax)) + 33'($signed(item.bx));
		sum12_s1 <= 33'($signed(item.bx)) + 33'($signed(item.cx));
		x0_s1    <= item.ax;
		y0_s1    <= item.ay;
		y1_s1    <= item.by;
		y2_s1    <= item.cy;
		lo_s1    <= lo_c;
		hi_s1    <= hi_c;
		lvl01_s1 <= item.by == item.ay;
		lvl12_s1 <= item.cy == item.by;
	end

	// stage 2: products
	logic               vld_s2;
	logic signed [65:0] p_bxqy_s2, p_byqx_s2, p_e1e2_s2, p_bxqx_s2;
	logic signed [65:0] sq_bx_s2, sq_by_s2, sq_qx_s2, sq_qy_s2;
	logic signed [63:0] sq_y0_s2, sq_y1_s2, sq_y2_s2;
	logic signed [32:0] dbx_s2, dby_s2, dqx_s2, dqy_s2, sum01_s2, sum12_s2, sumall_s2;
	logic signed [31:0] x0_s2, y0_s2;
	logic               lvl01_s2, lvl12_s2;

	always_ff @(posedge clk) begin
		p_bxqy_s2 <= 66'(dbx_s1) * 66'(dqy_s1);
		p_byqx_s2 <= 66'(dby_s1) * 66'(dqx_s1);
		p_e1e2_s2 <= 66'(de1_s1) * 66'(de2_s1);
		p_bxqx_s2 <= 66'(dbx_s1) * 66'(dqx_s1);
		sq_bx_s2  <= 66'(dbx_s1) * 66'(dbx_s1);
		sq_by_s2  <= 66'(dby_s1) * 66'(dby_s1);
		sq_qx_s2  <= 66'(dqx_s1) * 66'(dqx_s1);
		sq_qy_s2  <= 66'(dqy_s1) * 66'(dqy_s1);
		sq_y0_s2  <= 64'(y0_s1) * 64'(y0_s1);
		sq_y1_s2  <= 64'(y1_s1) * 64'(y1_s1);
		sq_y2_s2  <= 64'(y2_s1) * 64'(y2_s1);
		sumall_s2 <= 33'(lo_s1) + 33'(hi_s1);
		dbx_s2    <= dbx_s1;
		dby_s2    <= dby_s1;
		dqx_s2    <= dqx_s1;
		dqy_s2    <= dqy_s1;
		sum01_s2  <= sum01_s1;
		sum12_s2  <= sum12_s1;
		x0_s2     <= x0_s1;
		y0_s2     <= y0_s1;
		lvl01_s2  <= lvl01_s1;
		lvl12_s2  <= lvl12_s1;
	end

	// stage 3: determinant, squared lengths, level-edge numerators
	logic                vld_s3;
	logic signed [DNW-1:0] d_s3;
	logic [64:0]         b2_s3, c2_s3;
	logic signed [67:0]  numa_s3, numb_s3;
	logic signed [32:0]  dbx_s3, dby_s3, dqx_s3, dqy_s3, sum01_s3, sum12_s3, sumall_s3;
	logic signed [31:0]  x0_s3, y0_s3;
	logic                lvl01_s3, lvl12_s3;

	always_ff @(posedge clk) begin
		d_s3      <= (DNW'(p_bxqy_s2) - DNW'(p_byqx_s2)) <<< 1;
		b2_s3     <= sq_bx_s2[64:0] + sq_by_s2[64:0];
		c2_s3     <= sq_qx_s2[64:0] + sq_qy_s2[64:0];
		numa_s3   <= 68'(sq_y2_s2) - 68'(sq_y1_s2) - 68'(p_e1e2_s2);
		numb_s3   <= 68'(sq_y1_s2) - 68'(sq_y0_s2) - 68'(p_bxqx_s2);
		dbx_s3    <= dbx_s2;
		dby_s3    <= dby_s2;
		dqx_s3    <= dqx_s2;
		dqy_s3    <= dqy_s2;
		sum01_s3  <= sum01_s2;
		sum12_s3  <= sum12_s2;
		sumall_s3 <= sumall_s2;
		x0_s3     <= x0_s2;
		y0_s3     <= y0_s2;
		lvl01_s3  <= lvl01_s2;
		lvl12_s3  <= lvl12_s2;
	end

	// stage 4: partial products of the bisector numerators
	logic                  vld_s4;
	logic signed [65:0]    pl_b2qy_s4, pl_c2by_s4, pl_c2bx_s4, pl_b2qx_s4;
	logic signed [66:0]    ph_b2qy_s4, ph_c2by_s4, ph_c2bx_s4, ph_b2qx_s4;
	logic signed [DNW-1:0] d_s4;
	logic signed [67:0]    numa_s4, numb_s4;
	logic signed [32:0]    dby_s4, dqy_s4, sum01_s4, sum12_s4, sumall_s4;
	logic signed [31:0]    x0_s4, y0_s4;
	logic                  lvl01_s4, lvl12_s4;

	always_ff @(posedge clk) begin
		pl_b2qy_s4 <= 66'($signed({1'b0, b2_s3[31:0]})) * 66'(dqy_s3);
		pl_c2by_s4 <= 66'($signed({1'b0, c2_s3[31:0]})) * 66'(dby_s3);
		pl_c2bx_s4 <= 66'($signed({1'b0, c2_s3[31:0]})) * 66'(dbx_s3);
		pl_b2qx_s4 <= 66'($signed({1'b0, b2_s3[31:0]})) * 66'(dqx_s3);
		ph_b2qy_s4 <= 67'($signed({1'b0, b2_s3[64:32]})) * 67'(dqy_s3);
		ph_c2by_s4 <= 67'($signed({1'b0, c2_s3[64:32]})) * 67'(dby_s3);
		ph_c2bx_s4 <= 67'($signed({1'b0, c2_s3[64:32]})) * 67'(dbx_s3);
		ph_b2qx_s4 <= 67'($signed({1'b0, b2_s3[64:32]})) * 67'(dqx_s3);
		d_s4       <= d_s3;
		numa_s4    <= numa_s3;
		numb_s4    <= numb_s3;
		dby_s4     <= dby_s3;
		dqy_s4     <= dqy_s3;
		sum01_s4   <= sum01_s3;
		sum12_s4   <= sum12_s3;
		sumall_s4  <= sumall_s3;
		x0_s4      <= x0_s3;
		y0_s4      <= y0_s3;
		lvl01_s4   <= lvl01_s3;
		lvl12_s4   <= lvl12_s3;
	end

	// stage 5: full products
	logic                  vld_s5;
	logic signed [NW-1:0]  b2qy_s5, c2by_s5, c2bx_s5, b2qx_s5;
	logic signed [DNW-1:0] d_s5;
	logic signed [67:0]    numa_s5, numb_s5;
	logic signed [32:0]    dby_s5, dqy_s5, sum01_s5, sum12_s5, sumall_s5;
	logic signed [31:0]    x0_s5, y0_s5;
	logic                  lvl01_s5, lvl12_s5;

	always_ff @(posedge clk) begin
		b2qy_s5   <= (NW'(ph_b2qy_s4) <<< 32) + NW'(pl_b2qy_s4);
		c2by_s5   <= (NW'(ph_c2by_s4) <<< 32) + NW'(pl_c2by_s4);
		c2bx_s5   <= (NW'(ph_c2bx_s4) <<< 32) + NW'(pl_c2bx_s4);
		b2qx_s5   <= (NW'(ph_b2qx_s4) <<< 32) + NW'(pl_b2qx_s4);
		d_s5      <= d_s4;
		numa_s5   <= numa_s4;
		numb_s5   <= numb_s4;
		dby_s5    <= dby_s4;
		dqy_s5    <= dqy_s4;
		sum01_s5  <= sum01_s4;
		sum12_s5  <= sum12_s4;
		sumall_s5 <= sumall_s4;
		x0_s5     <= x0_s4;
		y0_s5     <= y0_s4;
		lvl01_s5  <= lvl01_s4;
		lvl12_s5  <= lvl12_s4;
	end

	// stage 6: case split into quotient operands
	logic                  vld_s6;
	logic signed [NW-1:0]  num_x_s6, num_y_s6, num_x_c, num_y_c;
	logic signed [DNW-1:0] den_x_s6, den_y_s6, den_x_c, den_y_c;
	logic                  gen_s6, coll_s6, gen_c;
	logic signed [31:0]    x0_s6, y0_s6;

	always_comb begin
		if (lvl01_s5 && lvl12_s5) begin
			num_x_c = NW'(sumall_s5);
			den_x_c = DNW'(2);
			num_y_c = NW'(y0_s5);
			den_y_c = DNW'(1);
			gen_c   = 1'b0;
		end else if (lvl01_s5) begin
			num_x_c = NW'(sum01_s5);
			den_x_c = DNW'(2);
			num_y_c = NW'(numa_s5);
			den_y_c = DNW'(dqy_s5) <<< 1;
			gen_c   = 1'b0;
		end else if (lvl12_s5) begin
			num_x_c = NW'(sum12_s5);
			den_x_c = DNW'(2);
			num_y_c = NW'(numb_s5);
			den_y_c = DNW'(dby_s5) <<< 1;
			gen_c   = 1'b0;
		end else begin
			num_x_c = b2qy_s5 - c2by_s5;
			den_x_c = d_s5;
			num_y_c = c2bx_s5 - b2qx_s5;
			den_y_c = d_s5;
			gen_c   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		num_x_s6 <= num_x_c;
		num_y_s6 <= num_y_c;
		den_x_s6 <= den_x_c;
		den_y_s6 <= den_y_c;
		gen_s6   <= gen_c;
		coll_s6  <= gen_c && (d_s5 == '0);
		x0_s6    <= x0_s5;
		y0_s6    <= y0_s5;
	end

	// quotient pipelines
	logic signed [QW-1:0] quo_x, quo_y;
	logic                 big_x, big_y, neg_x, neg_y;

	tcc_rdiv u_div_x (
		.clk (clk),
		.num (num_x_s6),
		.den (den_x_s6),
		.quo (quo_x),
		.big (big_x),
		.neg (neg_x)
	);

	tcc_rdiv u_div_y (
		.clk (clk),
		.num (num_y_s6),
		.den (den_y_s6),
		.quo (quo_y),
		.big (big_y),
		.neg (neg_y)
	);

	dsb_t dsb_q  [DL];
	logic dvld_q [DL];

	always_ff @(posedge clk) begin
		dsb_q[0] <= '{x0: x0_s6, y0: y0_s6, gen: gen_s6, coll: coll_s6};
		for (int i = 1; i < DL; i++) begin
			dsb_q[i] <= dsb_q[i-1];
		end
	end

	// p1: offset and clamp
	logic               vld_p1, sat_p1, coll_p1;
	logic signed [31:0] ccx_p1, ccy_p1, x0_p1, y0_p1;
	logic [32:0]        clx_c, cly_c;

	always_comb begin
		clx_c = clamp_coord(quo_x, big_x, neg_x, dsb_q[DL-1].gen ? dsb_q[DL-1].x0 : 32'sd0);
		cly_c = clamp_coord(quo_y, big_y, neg_y, dsb_q[DL-1].gen ? dsb_q[DL-1].y0 : 32'sd0);
	end

	always_ff @(posedge clk) begin
		ccx_p1  <= clx_c[31:0];
		ccy_p1  <= cly_c[31:0];
		sat_p1  <= clx_c[32] | cly_c[32];
		coll_p1 <= dsb_q[DL-1].coll;
		x0_p1   <= dsb_q[DL-1].x0;
		y0_p1   <= dsb_q[DL-1].y0;
	end

	// p2..p5: squared radius
	logic               vld_p2, vld_p3, vld_p4, vld_p5;
	logic signed [32:0] dx_p2, dy_p2;
	logic [31:0]        mx_p3, my_p3;
	logic [63:0]        sqx_p4, sqy_p4;
	logic [64:0]        r2sum_c;
	logic [62:0]        r2_p5;
	logic               ovf_p5;
	logic signed [31:0] ccx_p2, ccy_p2, ccx_p3, ccy_p3, ccx_p4, ccy_p4, ccx_p5, ccy_p5;
	logic               sat_p2, sat_p3, sat_p4, sat_p5;
	logic               coll_p2, coll_p3, coll_p4, coll_p5;

	assign r2sum_c = 65'(sqx_p4) + 65'(sqy_p4);

	always_ff @(posedge clk) begin
		dx_p2   <= 33'(x0_p1) - 33'(ccx_p1);
		dy_p2   <= 33'(y0_p1) - 33'(ccy_p1);
		mx_p3   <= dx_p2[32] ? 32'(-dx_p2) : dx_p2[31:0];
		my_p3   <= dy_p2[32] ? 32'(-dy_p2) : dy_p2[31:0];
		sqx_p4  <= 64'(mx_p3) * 64'(mx_p3);
		sqy_p4  <= 64'(my_p3) * 64'(my_p3);
		r2_p5   <= r2sum_c[62:0];
		ovf_p5  <= |r2sum_c[64:63];
		ccx_p2  <= ccx_p1;
		ccy_p2  <= ccy_p1;
		ccx_p3  <= ccx_p2;
		ccy_p3  <= ccy_p2;
		ccx_p4  <= ccx_p3;
		ccy_p4  <= ccy_p3;
		ccx_p5  <= ccx_p4;
		ccy_p5  <= ccy_p4;
		sat_p2  <= sat_p1;
		sat_p3  <= sat_p2;
		sat_p4  <= sat_p3;
		sat_p5  <= sat_p4;
		coll_p2 <= coll_p1;
		coll_p3 <= coll_p2;
		coll_p4 <= coll_p3;
		coll_p5 <= coll_p4;
	end

	// square root
	logic [tcc_pkg::RAD_W-1:0] root;

	tcc_isqrt u_isqrt (
		.clk   (clk),
		.value (r2_p5),
		.root  (root)
	);

	ssb_t ssb_q  [SL];
	logic svld_q [SL];

	always_ff @(posedge clk) begin
		ssb_q[0] <= '{ccx: ccx_p5, ccy: ccy_p5, sat: sat_p5, coll: coll_p5, ovf: ovf_p5,
			r2s: 64'(r2_p5) + 64'(r2_p5 >> tcc_pkg::RSQ_SHIFT)};
		for (int i = 1; i < SL; i++) begin
			ssb_q[i] <= ssb_q[i-1];
		end
	end

	// output register
	tcc_pkg::result_t result_q, result_c;
	ssb_t             last;

	assign last = ssb_q[SL-1];

	always_comb begin
		result_c.center_x  = last.ccx;
		result_c.center_y  = last.ccy;
		result_c.radius_sq = last.r2s[62:0];
		result_c.radius    = root;
		result_c.status    = tcc_pkg::ST_OK;
		if (last.coll) begin
			result_c.center_x  = '0;
			result_c.center_y  = '0;
			result_c.radius_sq = '1;
			result_c.radius    = '1;
			result_c.status    = tcc_pkg::ST_COLLINEAR;
		end else if (last.sat || last.ovf) begin
			result_c.radius_sq = '1;
			result_c.radius    = '1;
			result_c.status    = tcc_pkg::ST_SAT;
		end else if (last.r2s[63]) begin
			result_c.radius_sq = '1;
			result_c.status    = tcc_pkg::ST_SAT;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_c;
	end

	assign result = result_q;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_p1 <= 1'b0;
			vld_p2 <= 1'b0;
			vld_p3 <= 1'b0;
			vld_p4 <= 1'b0;
			vld_p5 <= 1'b0;
			done   <= 1'b0;
			for (int i = 0; i < DL; i++) dvld_q[i] <= 1'b0;
			for (int i = 0; i < SL; i++) svld_q[i] <= 1'b0;
		end else begin
			vld_s1    <= start && !busy;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			dvld_q[0] <= vld_s6;
			for (int i = 1; i < DL; i++) dvld_q[i] <= dvld_q[i-1];
			vld_p1    <= dvld_q[DL-1];
			vld_p2    <= vld_p1;
			vld_p3    <= vld_p2;
			vld_p4    <= vld_p3;
			vld_p5    <= vld_p4;
			svld_q[0] <= vld_p5;
			for (int i = 1; i < SL; i++) svld_q[i] <= svld_q[i-1];
			done      <= svld_q[SL-1];
		end
	end

	a_collinear_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == tcc_pkg::ST_COLLINEAR |->
			result.center_x == 32'sd0 && result.center_y == 32'sd0 &&
			(&result.radius_sq) && (&result.radius))
		else $error("collinear result not in its fixed form");

	a_radius_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == tcc_pkg::ST_OK |->
			{1'b0, result.radius_sq} >= 64'(result.radius) * 64'(result.radius))
		else $error("radius squared exceeds squared radius");

	a_sat_radius: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == tcc_pkg::ST_SAT && !(&result.radius) |->
			&result.radius_sq)
		else $error("saturated result with a finite squared radius");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_p5, tcc_pkg::SQ_LAT + 1))
		else $error("result strobe without a transfer in flight");

endmodule

// ===== verif/triangle_circumcircle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_circumcircle_checker
// Watches the vertex and result transfers of the circumcircle block, works
// out the expected centre, squared radius, radius and status of every
// accepted triangle, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module triangle_circumcircle_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  tcc_pkg::vertices_t item,
	input  logic               done,
	input  tcc_pkg::result_t   result,
	output int                 failures,
	output int                 outstanding
);

	typedef logic signed [129:0] wide_t;

	localparam logic [62:0] ALL_ONES_63 = {63{1'b1}};
	localparam wide_t       QUOT_LIM    = wide_t'(1) <<< 62;
	localparam wide_t       COORD_MAX   = (wide_t'(1) <<< 31) - wide_t'(1);
	localparam wide_t       COORD_MIN   = -(wide_t'(1) <<< 31);

	tcc_pkg::result_t pending_results[$];

	// floor((2n + d) / 2d): nearest, ties toward plus infinity, then clamped
	function automatic wide_t rounded_quotient(wide_t n, wide_t d);
		wide_t m, t, q;
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		m = 2 * n + d;
		t = 2 * d;
		q = m / t;
		if (m < 0 && (m % t) != 0)
			q = q - 1;
		if (q > QUOT_LIM)
			q = QUOT_LIM;
		if (q < -QUOT_LIM)
			q = -QUOT_LIM;
		return q;
	endfunction

	function automatic logic [31:0] floor_sqrt(logic [62:0] v);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int i = 31; i >= 0; i--) begin
			trial = root | (32'd1 << i);
			if (64'(trial) * 64'(trial) <= 64'(v))
				root = trial;
		end
		return root;
	endfunction

	function automatic tcc_pkg::result_t circumcircle_of(tcc_pkg::vertices_t v);
		wide_t x0, y0, x1, y1, x2, y2, y10, y21, lo, hi;
		wide_t ex, ey, fx, fy, det, b2, c2, nx, ny, ccx, ccy, dx, dy, r2, r2s;
		logic sat;
		tcc_pkg::result_t r;
		x0 = v.ax; y0 = v.ay; x1 = v.bx; y1 = v.by; x2 = v.cx; y2 = v.cy;
		y10 = y1 - y0;
		y21 = y2 - y1;
		r.radius_sq = ALL_ONES_63;
		r.radius = '1;
		r.status = tcc_pkg::ST_OK;
		if (y10 == 0 && y21 == 0) begin
			lo = x0;
			hi = x1;
			if (x1 > x0) begin
				if (x2 > x1) hi = x2;
			end else begin
				if (x2 < x0) lo = x2;
			end
			ccx = rounded_quotient(lo + hi, 2);
			ccy = y0;
		end else if (y10 == 0) begin
			ccx = rounded_quotient(x0 + x1, 2);
			ccy = rounded_quotient(y2 * y2 - y1 * y1 - (x2 - x1) * (x0 - x2), 2 * y21);
		end else if (y21 == 0) begin
			ccx = rounded_quotient(x1 + x2, 2);
			ccy = rounded_quotient(y1 * y1 - y0 * y0 - (x1 - x0) * (x2 - x0), 2 * y10);
		end else begin
			ex = x1 - x0; ey = y10; fx = x2 - x0; fy = y2 - y0;
			det = 2 * (ex * fy - ey * fx);
			if (det == 0) begin
				r.center_x = '0;
				r.center_y = '0;
				r.status = tcc_pkg::ST_COLLINEAR;
				return r;
			end
			b2 = ex * ex + ey * ey;
			c2 = fx * fx + fy * fy;
			nx = b2 * fy - c2 * ey;
			ny = c2 * ex - b2 * fx;
			ccx = x0 + rounded_quotient(nx, det);
			ccy = y0 + rounded_quotient(ny, det);
		end
		sat = 1'b0;
		if (ccx > COORD_MAX) begin ccx = COORD_MAX; sat = 1'b1; end
		if (ccx < COORD_MIN) begin ccx = COORD_MIN; sat = 1'b1; end
		if (ccy > COORD_MAX) begin ccy = COORD_MAX; sat = 1'b1; end
		if (ccy < COORD_MIN) begin ccy = COORD_MIN; sat = 1'b1; end
		r.center_x = ccx[31:0];
		r.center_y = ccy[31:0];
		if (sat) begin
			r.status = tcc_pkg::ST_SAT;
			return r;
		end
		dx = x0 - ccx;
		dy = y0 - ccy;
		r2 = dx * dx + dy * dy;
		if (r2 > wide_t'(ALL_ONES_63)) begin
			r.status = tcc_pkg::ST_SAT;
			return r;
		end
		r.radius = floor_sqrt(r2[62:0]);
		r2s = r2 + (r2 >>> 20);
		if (r2s > wide_t'(ALL_ONES_63))
			r.status = tcc_pkg::ST_SAT;
		else
			r.radius_sq = r2s[62:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			failures++;
			$display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
		end
	endtask

	assign outstanding = pending_results.size();

	initial failures = 0;

	always @(posedge clk) begin
		tcc_pkg::result_t want;
		if (arst_n) begin
			if (start && !busy)
				pending_results.push_back(circumcircle_of(item));
			if (done) begin
				if (pending_results.size() == 0) begin
					failures++;
					$display("%0t unexpected result: expected none actual %h", $time, result);
				end else begin
					want = pending_results.pop_front();
					check_field("center_x", 64'(want.center_x), 64'(result.center_x));
					check_field("center_y", 64'(want.center_y), 64'(result.center_y));
					check_field("radius_sq", 64'(want.radius_sq), 64'(result.radius_sq));
					check_field("radius", 64'(want.radius), 64'(result.radius));
					check_field("status", 64'(want.status), 64'(result.status));
				end
			end
		end
	end

endmodule

// ===== verif/triangle_circumcircle_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_circumcircle_test
// Drives directed and random triangles into the circumcircle block with
// random gaps between transfers; the checker beside the block predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module triangle_circumcircle_test;

	localparam int RANDOM_ITEMS = 700;
	localparam int IDLE_LIMIT   = 3000;
	localparam int TAIL_CYCLES  = 120;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	tcc_pkg::vertices_t item = '0;
	logic               done;
	tcc_pkg::result_t   result;
	int                 failures;
	int                 outstanding;
	int                 idle_cycles = 0;
	bit                 gaps_on = 1'b1;

	always #6 clk = ~clk;

	triangle_circumcircle DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	triangle_circumcircle_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .failures(failures), .outstanding(outstanding)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send(logic signed [31:0] x0, y0, x1, y1, x2, y2);
		int gap;
		gap = gaps_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= '{ax: x0, ay: y0, bx: x1, by: y1, cx: x2, cy: y2};
		do @(posedge clk); while (busy);
	endtask

	function automatic logic signed [31:0] near_coord();
		return $signed(32'($urandom_range(0, 32'h000F_FFFF))) - 32'sh0008_0000;
	endfunction

	initial begin
		logic signed [31:0] x0, y0, x1, y1, x2, y2, k;
		logic signed [31:0] MAXV, MINV;
		MAXV = 32'sh7FFF_FFFF;
		MINV = 32'sh8000_0000;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all three level, four orderings of x and a repeated vertex
		send(0, 5, 10, 5, 20, 5);
		send(20, 5, 10, 5, 0, 5);
		send(10, 5, 20, 5, 0, 5);
		send(3, -7, 3, -7, 3, -7);
		send(MINV, MAXV, MAXV, MAXV, 0, MAXV);
		// first pair level, second pair level, repeated vertices
		send(0, 0, 100, 0, 50, 80);
		send(7, 7, 7, 7, 1, 9);
		send(0, 50, 30, 0, 90, 0);
		send(MINV, MINV, MAXV, MINV, 0, MAXV);
		// general and collinear
		send(0, 0, 65536, 13, -400, 70000);
		send(0, 0, 1, 1, 2, 2);
		send(MINV, MINV, MAXV, MAXV, 0, 0);
		send(5, 5, 5, 9, 5, -3);
		// centre far outside, radius overflow and a further collinear case
		send(0, 0, 1, 1, 2, 1 + 1);
		send(0, 0, 1, 2, 2, 3);
		send(MINV, MINV, MAXV, MINV + 1, MINV + 1, MAXV);
		send(MAXV, MAXV, MINV, MAXV - 1, MAXV, MINV);
		send(MINV, 0, MAXV, 1, 0, MAXV);
		send(-1, -1, 1, -2, 2, 1);
		send(MAXV, MINV, MINV, MAXV, MAXV, MAXV);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				gaps_on = $urandom_range(0, 3) != 0;
			if (n == RANDOM_ITEMS / 2) begin
				start <= 1'b0;
				@(posedge clk);
				while (outstanding != 0) @(posedge clk);
			end
			if ($urandom_range(0, 1)) begin
				x0 = $urandom; y0 = $urandom; x1 = $urandom;
				y1 = $urandom; x2 = $urandom; y2 = $urandom;
			end else begin
				x0 = near_coord(); y0 = near_coord(); x1 = near_coord();
				y1 = near_coord(); x2 = near_coord(); y2 = near_coord();
			end
			case ($urandom_range(0, 9))
				0: begin y1 = y0; y2 = y0; end
				1: y1 = y0;
				2: y2 = y1;
				3: begin
					k = $signed(32'($urandom_range(0, 6))) - 3;
					x1 = x0 + $signed(32'($urandom_range(0, 2000))) - 1000;
					y1 = y0 + $signed(32'($urandom_range(0, 2000))) - 1000;
					x2 = x0 + k * (x1 - x0);
					y2 = y0 + k * (y1 - y0);
				end
				4: begin x1 = x0; y1 = y0; end
				default: ;
			endcase
			send(x0, y0, x1, y1, x2, y2);
		end
		start <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
